FILE: sv/q16_pkg.sv
// Package for the Q16.16 fixed-point arithmetic unit.
// Holds widths, operation codes and status codes.
// Depends on nothing.
package q16_pkg;

    localparam int WordBits     = 32;
    localparam int FracBitsDflt = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

endpackage

FILE: sv/q16_divider.sv
// Pipelined restoring divider for operand magnitudes, one quotient bit per stage.
// Produces the quotient and the rounding decision; depends on q16_pkg.
module q16_divider
    import q16_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDflt
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [WordBits-1:0]           dividend,
    input  logic [WordBits-1:0]           divisor,
    output logic [WordBits+FRAC_BITS-1:0] quotient,
    output logic                          round_up
);
    localparam int NumBits = WordBits + FRAC_BITS;

    // Stage i holds the partial remainder after i quotient bits.
    logic [NumBits-1:0]  num_reg  [NumBits+1];
    logic [WordBits:0]   rem_reg  [NumBits+1];
    logic [WordBits-1:0] dvs_reg  [NumBits+1];

    always_comb
    begin
        num_reg[0] = {dividend, {FRAC_BITS{1'b0}}};
        rem_reg[0] = '0;
        dvs_reg[0] = divisor;
    end

    for (genvar i = 0; i < NumBits; i++)
    begin : g_stage
        logic [WordBits+1:0] shifted;
        logic [WordBits+1:0] diff;
        assign shifted = {rem_reg[i], num_reg[i][NumBits-1]};
        assign diff    = shifted - {2'b00, dvs_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvs_reg[i+1] <= dvs_reg[i];
                if (!diff[WordBits+1])
                begin
                    rem_reg[i+1] <= diff[WordBits:0];
                    num_reg[i+1] <= {num_reg[i][NumBits-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= shifted[WordBits:0];
                    num_reg[i+1] <= {num_reg[i][NumBits-2:0], 1'b0};
                end
            end
        end
    end

    // Output stage: registers the quotient and the rounding decision.
    logic [NumBits-1:0] quotient_reg;
    logic               round_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quotient_reg <= num_reg[NumBits];
            // Round half up: remainder >= divisor - remainder, i.e. 2*rem >= divisor.
            round_up_reg <= ({rem_reg[NumBits], 1'b0} >= {2'b00, dvs_reg[NumBits]});
        end
    end

    assign quotient = quotient_reg;
    assign round_up = round_up_reg;
endmodule

FILE: sv/q16_fixed_point_alu_core.sv
// Top level of the Q16.16 fixed-point arithmetic unit.
// Depends on q16_pkg and q16_divider.
//
// This unit accepts one word per cycle while the output is not stalled
// (command plus two signed Q16.16 operands) and returns one result word
// with a status, in order. The pipeline length is set by the restoring
// divider, which retires one quotient bit per pipeline stage; all operations
// travel the same pipeline so results stay in order. A stall on the output
// freezes the whole pipeline, and the input ready is high whenever the output slot is free or being taken.
module q16_16_fixed_point_alu_core
    import q16_pkg::*;
#(
    parameter int FRACTION_BITS = FracBitsDflt
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [1:0] command, [33:2] operand_a, [65:34] operand_b, [71:66] zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [31:0] result_value, [33:32] status, [39:34] zero
    output logic [39:0] m_axis_tdata
);
    localparam int NumBits = WordBits + FRACTION_BITS;
    localparam int Depth   = NumBits + 3;

    // Pipeline advances whenever the output slot is free or being taken.
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [Depth-1:0] vld_reg;

    // Stage 1: decode, magnitudes.
    logic [1:0]          cmd_reg [Depth];
    logic                neg_reg [Depth];
    logic [WordBits-1:0] ma_reg, mb_reg, sa_reg, sb_reg;

    logic [WordBits-1:0] in_a, in_b;
    assign in_a = s_axis_tdata[33:2];
    assign in_b = s_axis_tdata[65:34];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg[0] <= s_axis_tdata[1:0];
            neg_reg[0] <= in_a[WordBits-1] ^ in_b[WordBits-1];
            ma_reg <= in_a[WordBits-1] ? (~in_a + 1'b1) : in_a;
            mb_reg <= in_b[WordBits-1] ? (~in_b + 1'b1) : in_b;
            sa_reg <= in_a;
            sb_reg <= in_b;
        end
    end

    // Stage 2: add/sub result and status, and magnitude product.
    logic [WordBits-1:0]   sum_c;
    logic                  ovf_c;
    logic [2*WordBits-1:0] prod_reg;
    logic [WordBits-1:0]   as_reg [Depth];
    logic [1:0]            ast_reg [Depth];
    logic                  bz_reg [Depth];

    always_comb
    begin
        if (cmd_reg[0] == OP_ADD)
        begin
            sum_c = sa_reg + sb_reg;
            ovf_c = !(sa_reg[WordBits-1] ^ sb_reg[WordBits-1]) &&
                    (sa_reg[WordBits-1] ^ sum_c[WordBits-1]);
        end
        else
        begin
            sum_c = sa_reg - sb_reg;
            ovf_c = (sa_reg[WordBits-1] ^ sb_reg[WordBits-1]) &&
                    (sa_reg[WordBits-1] ^ sum_c[WordBits-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= ma_reg * mb_reg;
            as_reg[1]  <= sum_c;
            ast_reg[1] <= ovf_c ? ST_OVF : ST_OK;
            bz_reg[1]  <= (mb_reg == '0);
            cmd_reg[1] <= cmd_reg[0];
            neg_reg[1] <= neg_reg[0];
        end
    end

    // Stage 3: signed, rounded, shifted product with range check.
    logic [2*WordBits-1:0] sp_c;
    logic [2*WordBits-1:0] sh_c;
    logic [WordBits-1:0]   mr_reg [Depth];
    logic [1:0]            mst_reg [Depth];

    always_comb
    begin
        sp_c = (neg_reg[1] ? (~prod_reg + 1'b1) : prod_reg)
               + ({{(2*WordBits-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1));
        sh_c = $unsigned($signed(sp_c) >>> FRACTION_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mr_reg[2]  <= sh_c[WordBits-1:0];
            mst_reg[2] <= (sh_c[2*WordBits-1:WordBits-1] == '0 ||
                           sh_c[2*WordBits-1:WordBits-1] == '1) ? ST_OK : ST_OVF;
        end
    end

    // Delay lines carrying side results alongside the divider.
    for (genvar s = 2; s < Depth; s++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cmd_reg[s] <= cmd_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                as_reg[s]  <= as_reg[s-1];
                ast_reg[s] <= ast_reg[s-1];
                bz_reg[s]  <= bz_reg[s-1];
            end
        end
    end
    for (genvar s = 3; s < Depth; s++)
    begin : g_mdly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mr_reg[s]  <= mr_reg[s-1];
                mst_reg[s] <= mst_reg[s-1];
            end
        end
    end

    // Divider: starts from the first-stage magnitudes; after its NumBits
    // stages and its output register it lines up with delay-line stage
    // Depth-2.
    logic [NumBits-1:0] quo;
    logic               rnd;

    q16_divider #(.FRAC_BITS(FRACTION_BITS)) u_div
    (
        .clk      (clk),
        .en       (adv),
        .dividend (ma_reg),
        .divisor  (mb_reg),
        .quotient (quo),
        .round_up (rnd)
    );

    // Final stage: round quotient, select result, drive output register.
    logic [NumBits:0]    q_c;
    logic [WordBits-1:0] dr_c;
    logic [1:0]          dst_c;
    logic [WordBits-1:0] res_c;
    logic [1:0]          st_c;
    localparam int Tap = NumBits + 1;

    always_comb
    begin
        q_c = {1'b0, quo} + {{NumBits{1'b0}}, rnd};
        if (bz_reg[Tap])
            dst_c = ST_DIV0;
        else if (neg_reg[Tap] ?
                 (q_c > {{(NumBits+1-WordBits){1'b0}}, 1'b1, {(WordBits-1){1'b0}}}) :
                 (q_c[NumBits:WordBits-1] != '0))
            dst_c = ST_OVF;
        else
            dst_c = ST_OK;
        dr_c = neg_reg[Tap] ? (~q_c[WordBits-1:0] + 1'b1) : q_c[WordBits-1:0];
        case (cmd_reg[Tap])
            OP_ADD, OP_SUB:
            begin
                res_c = as_reg[Tap];
                st_c  = ast_reg[Tap];
            end
            OP_MUL:
            begin
                res_c = mr_reg[Tap];
                st_c  = mst_reg[Tap];
            end
            default:
            begin
                res_c = dr_c;
                st_c  = dst_c;
            end
        endcase
        if (st_c != ST_OK)
            res_c = '0;
    end

    logic [WordBits-1:0] res_reg;
    logic [1:0]          st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_c;
            st_reg  <= st_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    assign m_axis_tvalid = vld_reg[Depth-1];
    assign m_axis_tdata  = {6'b0, st_reg, res_reg};

    // A stalled output must hold its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // Nonzero status always comes with a zero result.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33:32] != ST_OK |-> m_axis_tdata[31:0] == '0)
        else $error("error status with nonzero result");

    // Ready follows the output slot only.
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
endmodule
